// ----- sv/cvos_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel output shaper package
// Shared codes, fixed widths and the sine table entry function for the
// control-voltage channel output shaper.
// ----------------------------------------------------------------------------
package cvos_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_MIN_VOLTAGE,
      REG_MAX_VOLTAGE,
      REG_ACTIVE_CHANNELS,
      REG_GLOBAL_MODE,
      REG_GLOBAL_SIGNAL_TYPE,
      REG_CHANNEL_MODE_MAP,
      REG_CHANNEL_TYPE_MAP,
      REG_SAMPLE_RATE
   } reg_index_type;

   // Requested output mode, as held in the global and per-channel registers.
   typedef enum logic [1:0] {
      MODE_AUTO,
      MODE_DC,
      MODE_PWM,
      MODE_AUDIO
   } mode_code_type;

   // Signal type, as held in the global and per-channel registers.
   typedef enum logic [1:0] {
      TYPE_AUTO,
      TYPE_CV,
      TYPE_AUDIO,
      TYPE_UNKNOWN
   } signal_type_code_type;

   // Mode reported with each result.
   typedef enum logic [1:0] {
      APPLIED_DC,
      APPLIED_PWM,
      APPLIED_AUDIO
   } applied_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_CHANNEL,
      STATUS_EMPTY_RANGE
   } status_type;

   localparam int CSR_DATA_W = 18;   // widest register (sample rate)
   localparam int DIV_W      = 18;   // divisor and remainder width
   localparam int N_W        = 17;   // normalized voltage, 0..65536
   localparam int FREQ_W     = 28;   // oscillator frequency in Q16 Hz
   localparam int MAP_CHANNELS = 8;  // channels covered by the mode and type maps

   localparam logic [FREQ_W-1:0] FREQ_BASE  = 28'd13107200;  // 200 Hz in Q16
   localparam logic [FREQ_W-1:0] FREQ_SLOPE = 28'd2000;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Half-scale sine for a position of one turn given in Q32. Evaluated at
   // elaboration only; the Taylor series is taken through the eleventh power.
   function automatic logic signed [15:0] sine_from_turn(input logic [63:0] turn);
      logic [63:0] quad;
      logic [63:0] u;
      logic [63:0] r;
      logic [63:0] r2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] mag;
      quad = (turn >> 30) & 64'd3;
      u    = turn & (Q30_ONE - 64'd1);
      if (quad[0]) begin
         u = Q30_ONE - u;
      end
      r    = (u * HALF_PI_Q30) >> 30;
      r2   = (r * r) >> 30;
      term = Q30_ONE;
      term = Q30_ONE - ((r2 * term) >> 30) / 64'd110;
      term = Q30_ONE - ((r2 * term) >> 30) / 64'd72;
      term = Q30_ONE - ((r2 * term) >> 30) / 64'd42;
      term = Q30_ONE - ((r2 * term) >> 30) / 64'd20;
      term = Q30_ONE - ((r2 * term) >> 30) / 64'd6;
      s    = (r * term) >> 30;
      mag  = (s * 64'd16384 + (Q30_ONE >> 1)) >> 30;
      if (mag > 64'd16384) begin
         mag = 64'd16384;
      end
      return quad[1] ? -$signed(16'(mag)) : $signed(16'(mag));
   endfunction

endpackage

// ----- sv/cv_channel_output_shaper_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel output shaper core
// Clamps and normalizes a channel voltage, resolves the output mode and
// produces a DC level, a PWM level or a half-scale sine sample per channel.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time and takes a new one only when
// req_stall is low. The normalized voltage is formed by a bit-serial restoring
// divider that yields one quotient bit per cycle. A rejected transaction goes
// from setup straight to the result; a DC or PWM transaction passes through
// the divider and the apply step; an audio transaction then makes a second
// pass through the same divider for the oscillator step, over 28 + max(0,
// PHASE_BITS - 16) dividend bits, followed by the phase update, the table
// index scaling and the registered sine table read. A finished result is
// held in the output register, so the next transaction is taken while it
// still waits to be collected. Phase state lives in flip-flops and is cleared
// by reset at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module cv_channel_output_shaper_core import cvos_pkg::*; #(
   parameter int CHANNELS         = 8,
   parameter int PHASE_BITS       = 16,
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [4:0]            req_channel,
   input  logic signed [15:0]    req_voltage,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_sample,
   output logic [1:0]            rsp_applied_mode,
   output logic [1:0]            rsp_status
);

   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH);
   localparam int QW      = (PHASE_BITS > N_W) ? PHASE_BITS : N_W;
   localparam int SHL     = (PHASE_BITS > 16) ? PHASE_BITS - 16 : 0;
   localparam int SHR     = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
   localparam int DW      = FREQ_W + SHL;
   localparam int CNT_W   = $clog2(DW + 1);
   localparam int PROD_W  = PHASE_BITS + DEPTH_W + 1;

   localparam logic [63:0] PWM_STEP_WIDE = ((64'd1 << PHASE_BITS) + 64'd50) / 64'd100;
   localparam logic [PHASE_BITS-1:0] PWM_STEP = PHASE_BITS'(PWM_STEP_WIDE);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_DIV_N,
      S_APPLY,
      S_DIV_STEP,
      S_TONE,
      S_SCALE,
      S_ROM,
      S_DONE
   } state_type;

   // Configuration registers
   logic signed [15:0]  min_ff;
   logic signed [15:0]  max_ff;
   logic [3:0]          active_ff;
   logic [1:0]          gmode_ff;
   logic [1:0]          gtype_ff;
   logic [15:0]         mode_map_ff;
   logic [15:0]         type_map_ff;
   logic [DIV_W-1:0]    rate_ff;

   // Control and datapath
   state_type           state_ff;
   logic [4:0]          ch_ff;
   logic signed [15:0]  volt_ff;
   applied_type         mode_ff;
   logic [DIV_W-1:0]    rem_ff;
   logic [DIV_W-1:0]    div_ff;
   logic [DW-1:0]       dvd_ff;
   logic [QW-1:0]       quo_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [N_W-1:0]      n_ff;
   logic [PHASE_BITS-1:0] tone_p_ff;
   logic [DEPTH_W-1:0]  idx_ff;
   logic [PHASE_BITS-1:0] pwm_phase_ff [CHANNELS];
   logic [PHASE_BITS-1:0] tone_phase_ff [CHANNELS];

   logic signed [15:0]  res_sample_ff;
   applied_type         res_mode_ff;
   status_type          res_status_ff;

   logic                rsp_valid_ff;
   logic signed [15:0]  rsp_sample_ff;
   applied_type         rsp_mode_ff;
   status_type          rsp_status_ff;

   // Combinational signals
   logic                ch_reject;
   logic                range_empty;
   logic signed [15:0]  v_clamped;
   logic [N_W-1:0]      num_w;
   logic [N_W-1:0]      den_w;
   logic                ch_in_map;
   logic [1:0]          ch_mode;
   logic [1:0]          ch_type;
   logic [1:0]          mode_sel;
   logic [1:0]          type_sel;
   applied_type         applied_w;
   logic [CH_W-1:0]     ch_idx;
   logic [DIV_W:0]      rem_shift;
   logic                rem_ge;
   logic [DIV_W-1:0]    rem_in;
   logic [QW-1:0]       quo_in;
   logic [FREQ_W-1:0]   freq_in;
   logic [DW-1:0]       dvd_freq_in;
   logic [DIV_W-1:0]    rate_div;
   logic signed [15:0]  dc_sample;
   logic [PHASE_BITS-1:0] pwm_in;
   logic [PHASE_BITS+16:0] pwm_lhs;
   logic [PHASE_BITS+16:0] pwm_rhs;
   logic [PHASE_BITS-1:0] tone_in;
   logic [PROD_W-1:0]   prod_in;
   logic [DEPTH_W-1:0]  idx_in;
   logic signed [15:0]  sine_rom [SINE_TABLE_DEPTH];

   // Sine table, computed at elaboration.
   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
      localparam logic [63:0] TURN = (64'(g) << 32) / 64'(SINE_TABLE_DEPTH);
      assign sine_rom[g] = sine_from_turn(TURN);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff      <= -16'sd10240;
         max_ff      <= 16'sd10240;
         active_ff   <= 4'd8;
         gmode_ff    <= MODE_AUTO;
         gtype_ff    <= TYPE_AUTO;
         mode_map_ff <= '0;
         type_map_ff <= '0;
         rate_ff     <= 18'd44100;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_VOLTAGE:        min_ff      <= csr_wdata[15:0];
            REG_MAX_VOLTAGE:        max_ff      <= csr_wdata[15:0];
            REG_ACTIVE_CHANNELS:    active_ff   <= csr_wdata[3:0];
            REG_GLOBAL_MODE:        gmode_ff    <= csr_wdata[1:0];
            REG_GLOBAL_SIGNAL_TYPE: gtype_ff    <= csr_wdata[1:0];
            REG_CHANNEL_MODE_MAP:   mode_map_ff <= csr_wdata[15:0];
            REG_CHANNEL_TYPE_MAP:   type_map_ff <= csr_wdata[15:0];
            REG_SAMPLE_RATE:        rate_ff     <= csr_wdata;
            default:                rate_ff     <= rate_ff;
         endcase
      end
   end

   // Admission checks, clamping and the divider operands.
   assign ch_reject   = (ch_ff >= {1'b0, active_ff}) || (6'(ch_ff) >= 6'(CHANNELS));
   assign range_empty = (max_ff <= min_ff);

   always_comb begin
      v_clamped = volt_ff;
      if (volt_ff < min_ff) begin
         v_clamped = min_ff;
      end
      if (v_clamped > max_ff) begin
         v_clamped = max_ff;
      end
   end

   assign num_w = N_W'({v_clamped[15], v_clamped} - {min_ff[15], min_ff});
   assign den_w = N_W'({max_ff[15], max_ff} - {min_ff[15], min_ff});

   // Mode resolution: channel mode, global mode, channel type, global type.
   assign ch_in_map = (ch_ff < 5'(MAP_CHANNELS));
   assign ch_mode   = ch_in_map ? mode_map_ff[{ch_ff[2:0], 1'b0} +: 2] : MODE_AUTO;
   assign ch_type   = ch_in_map ? type_map_ff[{ch_ff[2:0], 1'b0} +: 2] : TYPE_AUTO;

   always_comb begin
      mode_sel = (ch_mode != MODE_AUTO) ? ch_mode : gmode_ff;
      type_sel = (ch_type != TYPE_AUTO) ? ch_type : gtype_ff;
      if (mode_sel == MODE_PWM) begin
         applied_w = APPLIED_PWM;
      end else if (mode_sel == MODE_AUDIO) begin
         applied_w = APPLIED_AUDIO;
      end else if (mode_sel == MODE_DC) begin
         applied_w = APPLIED_DC;
      end else if (type_sel == TYPE_AUDIO) begin
         applied_w = APPLIED_AUDIO;
      end else begin
         applied_w = APPLIED_DC;
      end
   end

   assign ch_idx = ch_ff[CH_W-1:0];

   // One restoring division step: the remainder always stays below the divisor.
   assign rem_shift = {rem_ff, dvd_ff[DW-1]};
   assign rem_ge    = (rem_shift >= {1'b0, div_ff});
   assign rem_in    = rem_ge ? DIV_W'(rem_shift - {1'b0, div_ff}) : rem_shift[DIV_W-1:0];
   assign quo_in    = {quo_ff[QW-2:0], rem_ge};

   // The oscillator step divides f * 2^PHASE_BITS by rate * 2^16; the 2^16
   // is folded into a fixed shift of the dividend.
   assign freq_in     = FREQ_BASE + FREQ_W'(FREQ_W'(n_ff) * FREQ_SLOPE);
   assign dvd_freq_in = (DW'(freq_in) << SHL) >> SHR;
   assign rate_div    = (rate_ff == '0) ? DIV_W'(1) : rate_ff;

   assign dc_sample = n_ff[N_W-1] ? 16'sh7FFF : {~n_ff[15], n_ff[14:0]};

   assign pwm_in  = pwm_phase_ff[ch_idx] + PWM_STEP;
   assign pwm_lhs = {1'b0, pwm_in, 16'b0};
   assign pwm_rhs = {n_ff, {PHASE_BITS{1'b0}}};

   assign tone_in = tone_phase_ff[ch_idx] + quo_ff[PHASE_BITS-1:0];
   assign prod_in = PROD_W'(tone_p_ff) * PROD_W'(SINE_TABLE_DEPTH);
   assign idx_in  = prod_in[PHASE_BITS +: DEPTH_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pwm_phase_ff[i]  <= '0;
            tone_phase_ff[i] <= '0;
         end
      end else begin
         // In S_DONE the output register is reloaded or held below.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  ch_ff    <= req_channel;
                  volt_ff  <= req_voltage;
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               res_sample_ff <= '0;
               res_mode_ff   <= APPLIED_DC;
               if (ch_reject) begin
                  res_status_ff <= STATUS_BAD_CHANNEL;
                  state_ff      <= S_DONE;
               end else if (range_empty) begin
                  res_status_ff <= STATUS_EMPTY_RANGE;
                  state_ff      <= S_DONE;
               end else begin
                  // num <= den, so the quotient bits above bit 16 are zero and
                  // the top sixteen bits of num can be preloaded.
                  res_status_ff <= STATUS_OK;
                  rem_ff        <= DIV_W'(num_w[N_W-1:1]);
                  div_ff        <= DIV_W'(den_w);
                  dvd_ff        <= {num_w[0], {(DW-1){1'b0}}};
                  cnt_ff        <= CNT_W'(N_W);
                  mode_ff       <= applied_w;
                  state_ff      <= S_DIV_N;
               end
            end
            S_DIV_N: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  n_ff     <= quo_in[N_W-1:0];
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               res_mode_ff <= mode_ff;
               unique case (mode_ff)
                  APPLIED_DC: begin
                     res_sample_ff <= dc_sample;
                     state_ff      <= S_DONE;
                  end
                  APPLIED_PWM: begin
                     pwm_phase_ff[ch_idx] <= pwm_in;
                     res_sample_ff        <= (pwm_lhs < pwm_rhs) ? 16'sh7FFF : 16'sh8000;
                     state_ff             <= S_DONE;
                  end
                  APPLIED_AUDIO: begin
                     rem_ff   <= '0;
                     div_ff   <= rate_div;
                     dvd_ff   <= dvd_freq_in;
                     cnt_ff   <= CNT_W'(DW);
                     state_ff <= S_DIV_STEP;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_DIV_STEP: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= S_TONE;
               end
            end
            S_TONE: begin
               tone_phase_ff[ch_idx] <= tone_in;
               tone_p_ff             <= tone_in;
               state_ff              <= S_SCALE;
            end
            S_SCALE: begin
               idx_ff   <= idx_in;
               state_ff <= S_ROM;
            end
            S_ROM: begin
               res_sample_ff <= sine_rom[idx_ff];
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sample_ff <= res_sample_ff;
                  rsp_mode_ff   <= res_mode_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_applied_mode = rsp_mode_ff;
   assign rsp_status       = rsp_status_ff;

   // The divider must keep its remainder below the divisor at every step.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_N || state_ff == S_DIV_STEP) |-> (rem_ff < div_ff))
      else $error("divider remainder not below divisor");

   // A rejected transaction carries a zero sample and the DC mode code.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_sample == 16'sd0 && rsp_applied_mode == APPLIED_DC))
      else $error("rejected transaction with non-zero result fields");

   // A PWM result is always one of the two full-scale levels.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_applied_mode == APPLIED_PWM) |->
         (rsp_sample == 16'sh7FFF || rsp_sample == 16'sh8000))
      else $error("PWM result not at full scale");

endmodule

// ----- bench/cv_channel_output_shaper_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel output shaper core testbench
// Offers channel and voltage transactions through a queue-fed driver, keeps
// its own copy of the registers and of the per-channel PWM and oscillator
// phases, and checks every result against the predicted sample, mode and
// status while both sides idle at random and the receiver holds off for a
// long stretch.
// ----------------------------------------------------------------------------
module cv_channel_output_shaper_core_tb;
   import cvos_pkg::*;

   localparam int          NUM_CHANNELS = 8;
   localparam logic [15:0] PWM_STEP     = (2 ** 16 + 50) / 100;
   localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
   localparam logic [63:0] QUARTER_RAD  = 64'd1686629713;   // pi/2 in Q30
   localparam logic [63:0] TONE_BASE    = 64'd13107200;     // 200 Hz in Q16
   localparam int          SETTLE_LIMIT = 40000;

   typedef struct {
      logic [4:0]  channel;
      logic [15:0] voltage;
   } shaper_request_type;

   typedef struct {
      logic signed [15:0] sample;
      applied_type        mode;
      status_type         status;
   } shaper_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write = 1'b0;
   logic [2:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [4:0]            req_channel = '0;
   logic signed [15:0]    req_voltage = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [15:0]    rsp_sample;
   logic [1:0]            rsp_applied_mode;
   logic [1:0]            rsp_status;

   // Register copy, starting from the reset values.
   logic signed [15:0]   cfg_min = -16'sd10240;
   logic signed [15:0]   cfg_max = 16'sd10240;
   logic [3:0]           cfg_active = 4'd8;
   mode_code_type        cfg_global_mode = MODE_AUTO;
   signal_type_code_type cfg_global_type = TYPE_AUTO;
   logic [15:0]          cfg_mode_map = '0;
   logic [15:0]          cfg_type_map = '0;
   logic [17:0]          cfg_rate = 18'd44100;

   logic [15:0] pwm_turn [NUM_CHANNELS] = '{default: '0};
   logic [15:0] tone_turn [NUM_CHANNELS] = '{default: '0};

   shaper_request_type pending_requests[$];
   shaper_result_type  expected_results[$];
   int              mismatch_count = 0;
   int              req_idle_pct = 11;
   int              rsp_idle_pct = 59;
   int              long_hold_left = 0;

   cv_channel_output_shaper_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_voltage      (req_voltage),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_applied_mode (rsp_applied_mode),
      .rsp_status       (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $realtime, what);
   endtask

   // Half-scale sine for one of 256 table positions, by a truncating Taylor
   // series in Q30 folded into the first quadrant.
   function automatic logic signed [15:0] half_sine(input logic [7:0] idx);
      logic [63:0] turn, quad, u, r, r2, term, s, mag;
      turn = 64'(idx) << 24;
      quad = (turn >> 30) & 64'd3;
      u    = turn & (ONE_Q30 - 64'd1);
      if (quad[0]) begin
         u = ONE_Q30 - u;
      end
      r    = (u * QUARTER_RAD) >> 30;
      r2   = (r * r) >> 30;
      term = ONE_Q30 - ((r2 * ONE_Q30) >> 30) / 64'd110;
      term = ONE_Q30 - ((r2 * term) >> 30) / 64'd72;
      term = ONE_Q30 - ((r2 * term) >> 30) / 64'd42;
      term = ONE_Q30 - ((r2 * term) >> 30) / 64'd20;
      term = ONE_Q30 - ((r2 * term) >> 30) / 64'd6;
      s    = (r * term) >> 30;
      mag  = (s * 64'd16384 + (ONE_Q30 >> 1)) >> 30;
      if (mag > 64'd16384) begin
         mag = 64'd16384;
      end
      return quad[1] ? -16'(mag) : 16'(mag);
   endfunction

   // Works out the result of one accepted transaction and advances the
   // phase of the channel it addresses.
   function automatic shaper_result_type shape_sample(input logic [4:0] ch,
                                                      input logic signed [15:0] volt);
      shaper_result_type    res;
      int                   lo, hi, v;
      logic [63:0]          n, freq, rate, step;
      mode_code_type        mode;
      signal_type_code_type stype;
      res.sample = '0;
      res.mode   = APPLIED_DC;
      res.status = STATUS_OK;
      lo = cfg_min;
      hi = cfg_max;
      v  = volt;
      if (ch >= cfg_active || ch >= NUM_CHANNELS) begin
         res.status = STATUS_BAD_CHANNEL;
         return res;
      end
      if (hi <= lo) begin
         res.status = STATUS_EMPTY_RANGE;
         return res;
      end
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      n = (64'(v - lo) << 16) / 64'(hi - lo);

      mode = (ch < NUM_CHANNELS) ? mode_code_type'(cfg_mode_map[2*ch +: 2]) : MODE_AUTO;
      if (mode == MODE_AUTO) begin
         mode = cfg_global_mode;
      end
      if (mode == MODE_AUTO) begin
         stype = (ch < NUM_CHANNELS) ?
                 signal_type_code_type'(cfg_type_map[2*ch +: 2]) : TYPE_AUTO;
         if (stype == TYPE_AUTO) begin
            stype = cfg_global_type;
         end
         mode = (stype == TYPE_AUDIO) ? MODE_AUDIO : MODE_DC;
      end

      case (mode)
         MODE_PWM: begin
            pwm_turn[ch] = pwm_turn[ch] + PWM_STEP;
            res.sample = (64'(pwm_turn[ch]) < n) ? 16'sh7FFF : 16'sh8000;
            res.mode   = APPLIED_PWM;
         end
         MODE_AUDIO: begin
            // A rate of zero counts as 1 Hz; a step beyond one turn wraps.
            rate = (cfg_rate == '0) ? 64'd1 : 64'(cfg_rate);
            freq = TONE_BASE + 64'd2000 * n;
            step = (freq << 16) / (rate << 16);
            tone_turn[ch] = tone_turn[ch] + step[15:0];
            res.sample = half_sine(tone_turn[ch][15:8]);
            res.mode   = APPLIED_AUDIO;
         end
         default: begin
            res.sample = (n > 64'd65535) ? 16'sh7FFF : 16'(n - 64'd32768);
            res.mode   = APPLIED_DC;
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : request_driver
      shaper_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(shape_sample(req_channel, req_voltage));
         end
         // A stalled transaction keeps its payload until it is taken.
         if (!(req_valid && req_stall)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               item = pending_requests.pop_front();
               req_valid   <= 1'b1;
               req_channel <= item.channel;
               req_voltage <= item.voltage;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_left != 0) begin
         rsp_stall <= 1'b1;
         long_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      shaper_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result: sample %0d mode %0d status %0d",
                                      rsp_sample, rsp_applied_mode, rsp_status));
         end else begin
            want = expected_results.pop_front();
            if (rsp_sample !== want.sample) begin
               report_mismatch($sformatf("sample %0d, expected %0d",
                                         rsp_sample, want.sample));
            end
            if (rsp_applied_mode !== want.mode) begin
               report_mismatch($sformatf("applied mode %0d, expected %0d",
                                         rsp_applied_mode, want.mode));
            end
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_status, want.status));
            end
         end
      end
   end

   // Writes one register, filling the unused upper data bits with noise.
   task automatic write_reg(input reg_index_type idx, input logic [17:0] value);
      logic [17:0] keep;
      case (idx) inside
         REG_ACTIVE_CHANNELS: keep = 18'h0000F;
         REG_GLOBAL_MODE, REG_GLOBAL_SIGNAL_TYPE: keep = 18'h00003;
         REG_SAMPLE_RATE: keep = 18'h3FFFF;
         default: keep = 18'h0FFFF;
      endcase
      value = value & keep;
      case (idx)
         REG_MIN_VOLTAGE:        cfg_min = value[15:0];
         REG_MAX_VOLTAGE:        cfg_max = value[15:0];
         REG_ACTIVE_CHANNELS:    cfg_active = value[3:0];
         REG_GLOBAL_MODE:        cfg_global_mode = mode_code_type'(value[1:0]);
         REG_GLOBAL_SIGNAL_TYPE: cfg_global_type = signal_type_code_type'(value[1:0]);
         REG_CHANNEL_MODE_MAP:   cfg_mode_map = value[15:0];
         REG_CHANNEL_TYPE_MAP:   cfg_type_map = value[15:0];
         default:                cfg_rate = value;
      endcase
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value | (18'($urandom()) & ~keep);
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic offer(input logic [4:0] ch, input logic [15:0] volt);
      shaper_request_type item;
      item.channel = ch;
      item.voltage = volt;
      pending_requests.push_back(item);
   endtask

   // The sender stops offering until every expected result has come back.
   task automatic settle();
      int waited;
      waited = 0;
      @(negedge clock);
      while ((pending_requests.size() != 0 || req_valid || expected_results.size() != 0)
             && waited < SETTLE_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_requests.size() != 0 || req_valid || expected_results.size() != 0) begin
         report_mismatch($sformatf("%0d results still outstanding",
                                   expected_results.size()));
         pending_requests.delete();
         expected_results.delete();
      end
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_voltage();
      int lo, hi, span, v;
      lo   = cfg_min;
      hi   = cfg_max;
      span = (hi > lo) ? hi - lo : 0;
      case ($urandom_range(9))
         0: v = int'($urandom_range(65535)) - 32768;
         1: v = $urandom_range(1) ? -32768 : 32767;
         2: v = $urandom_range(1) ? lo : hi;
         default: v = lo - 32 + int'($urandom_range(span + 64));
      endcase
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return 16'(v);
   endfunction

   function automatic logic [4:0] pick_channel();
      int reach;
      reach = (cfg_active < NUM_CHANNELS) ? int'(cfg_active) : NUM_CHANNELS;
      if (reach == 0 || $urandom_range(9) < 2) begin
         return 5'($urandom_range(31));
      end
      return 5'($urandom_range(reach - 1));
   endfunction

   task automatic scramble_setup(input bit empty_range);
      int lo, hi, a, b, act;
      case ($urandom_range(4))
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            lo = int'($urandom_range(65468)) - 32768;
            hi = lo + int'($urandom_range(24, 1));
         end
         2: begin
            lo = -10240;
            hi = 10240;
         end
         default: begin
            a  = int'($urandom_range(65535)) - 32768;
            b  = int'($urandom_range(65535)) - 32768;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (lo == hi) begin
               if (lo > -32768) lo = lo - 1;
               else hi = hi + 1;
            end
         end
      endcase
      if (empty_range) begin
         a  = lo;
         lo = hi;
         hi = $urandom_range(1) ? a : lo;
      end
      case ($urandom_range(9))
         0: act = 0;
         1: act = 1;
         2: act = 15;
         3: act = $urandom_range(14, 9);
         default: act = $urandom_range(8, 2);
      endcase
      write_reg(REG_MIN_VOLTAGE, 18'(lo));
      write_reg(REG_MAX_VOLTAGE, 18'(hi));
      write_reg(REG_ACTIVE_CHANNELS, 18'(act));
      write_reg(REG_GLOBAL_MODE, 18'($urandom_range(3)));
      write_reg(REG_GLOBAL_SIGNAL_TYPE, 18'($urandom_range(3)));
      write_reg(REG_CHANNEL_MODE_MAP, 18'($urandom_range(65535)));
      write_reg(REG_CHANNEL_TYPE_MAP, 18'($urandom_range(65535)));
      case ($urandom_range(7))
         0: write_reg(REG_SAMPLE_RATE, 18'd0);
         1: write_reg(REG_SAMPLE_RATE, 18'($urandom_range(999, 1)));
         2: write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
         3: write_reg(REG_SAMPLE_RATE, 18'd192000);
         4: write_reg(REG_SAMPLE_RATE, 18'd8000);
         default: write_reg(REG_SAMPLE_RATE, 18'($urandom_range(192000, 8000)));
      endcase
   endtask

   initial begin : stimulus
      int phase, count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: every channel resolves to DC over -10 V to +10 V.
      @(negedge clock);
      offer(5'd0, 16'h8000);
      offer(5'd7, 16'h7FFF);
      offer(5'd3, 16'h0000);
      offer(5'd8, 16'h0000);
      offer(5'd31, 16'hFFFF);
      settle();

      // Full range and PWM; channel 8 lies beyond the maps and the channel count.
      write_reg(REG_MIN_VOLTAGE, 18'h08000);
      write_reg(REG_MAX_VOLTAGE, 18'h07FFF);
      write_reg(REG_ACTIVE_CHANNELS, 18'd15);
      write_reg(REG_GLOBAL_MODE, MODE_PWM);
      offer(5'd0, 16'h7FFF);
      offer(5'd0, 16'h8000);
      offer(5'd8, 16'd100);
      offer(5'd5, 16'h0000);
      settle();

      // Audio at a sample rate of zero, where every step wraps several turns.
      write_reg(REG_GLOBAL_MODE, MODE_AUDIO);
      write_reg(REG_SAMPLE_RATE, 18'd0);
      offer(5'd1, 16'h8000);
      offer(5'd1, 16'h7FFF);
      offer(5'd6, 16'd1234);
      settle();

      // Audio reached through the global signal type at the highest rate.
      write_reg(REG_GLOBAL_MODE, MODE_AUTO);
      write_reg(REG_GLOBAL_SIGNAL_TYPE, TYPE_AUDIO);
      write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
      offer(5'd2, 16'h0000);
      offer(5'd2, 16'h7FFF);
      settle();

      // A channel count of zero rejects everything.
      write_reg(REG_ACTIVE_CHANNELS, 18'd0);
      offer(5'd0, 16'h0000);
      settle();

      // Empty voltage range, first equal bounds, then inverted ones.
      write_reg(REG_ACTIVE_CHANNELS, 18'd8);
      write_reg(REG_MIN_VOLTAGE, 18'd500);
      write_reg(REG_MAX_VOLTAGE, 18'd500);
      offer(5'd0, 16'd500);
      settle();
      write_reg(REG_MIN_VOLTAGE, 18'd600);
      write_reg(REG_MAX_VOLTAGE, 18'(-600));
      offer(5'd3, 16'h0000);
      settle();

      // The channels take the mode resolution through channel modes, channel types and the global type.
      write_reg(REG_MIN_VOLTAGE, 18'(-1024));
      write_reg(REG_MAX_VOLTAGE, 18'd1024);
      write_reg(REG_SAMPLE_RATE, 18'd8000);
      write_reg(REG_CHANNEL_MODE_MAP, {MODE_AUTO, MODE_AUTO, MODE_AUTO, MODE_AUTO,
                                       MODE_AUDIO, MODE_PWM, MODE_DC, MODE_AUTO});
      write_reg(REG_CHANNEL_TYPE_MAP, {TYPE_AUTO, TYPE_UNKNOWN, TYPE_AUDIO, TYPE_CV,
                                       TYPE_AUTO, TYPE_AUTO, TYPE_AUTO, TYPE_AUDIO});
      offer(5'd0, 16'd512);
      offer(5'd1, 16'(-2000));
      offer(5'd2, 16'd1000);
      offer(5'd3, 16'h0000);
      offer(5'd4, 16'd300);
      offer(5'd5, 16'(-1024));
      offer(5'd6, 16'd1024);
      offer(5'd7, 16'd700);
      settle();

      for (phase = 0; phase < 12; phase++) begin
         scramble_setup(phase == 7);
         req_idle_pct = (phase < 4) ? 11 : (phase < 8) ? 59 : 0;
         rsp_idle_pct = (phase < 4) ? 59 : (phase < 8) ? 11 : 0;
         count = (phase == 7) ? 40 : 170;
         repeat (count) offer(pick_channel(), pick_voltage());
         // Hold the result side off long enough for the block to back up.
         if (phase == 1) begin
            long_hold_left = 400;
         end
         settle();
      end

      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cv_channel_output_shaper_core regression: pass");
      end else begin
         $display("cv_channel_output_shaper_core regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("cv_channel_output_shaper_core regression: fail");
      $finish;
   end

endmodule
